>>> rtl/rmd_pkg.sv
// RIPEMD-128 hash: shared types, constants, step tables and round functions.
// No dependencies; used by every file of the block but rmd_ram.
package rmd_pkg;

    localparam int WordW  = 32;
    localparam int BlkWds = 16;
    localparam int AddrW  = 4;
    localparam int CntW   = 61;

    typedef logic [3:0][WordW-1:0] t_cv;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out;

    localparam t_cv IV = {32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301};

    localparam logic [31:0] KL [4] = '{32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc};
    localparam logic [31:0] KR [4] = '{32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h00000000};

    localparam logic [3:0] WL [64] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
        4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
        4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
        4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
        4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2};
    localparam logic [3:0] WR [64] = '{
        4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
        4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
        4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
        4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
        4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
        4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
        4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
        4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14};
    localparam logic [3:0] SL [64] = '{
        4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
        4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
        4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
        4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
        4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
        4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
        4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
        4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12};
    localparam logic [3:0] SR [64] = '{
        4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
        4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
        4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
        4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
        4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
        4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
        4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
        4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8};

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [3:0] s);
        logic [63:0] d;
        d = {v, v} << s;
        return d[63:32];
    endfunction

    function automatic logic [31:0] mix(input logic [1:0] sel, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z);
        logic [31:0] r;
        case (sel)
            2'd0:    r = x ^ y ^ z;
            2'd1:    r = (x & y) | (~x & z);
            2'd2:    r = (x | ~y) ^ z;
            default: r = (x & z) | (y & ~z);
        endcase
        return r;
    endfunction

endpackage

>>> rtl/rmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rmd_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/rmd_comp.sv
// RIPEMD-128 compression engine: chaining words, two-line step unit, read sequencing.
// Depends on rmd_pkg; reads message words from two block RAM ports.
module rmd_comp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_init,
    output logic [rmd_pkg::AddrW-1:0] o_raddr_l,
    output logic [rmd_pkg::AddrW-1:0] o_raddr_r,
    input  logic [31:0]               i_word_l,
    input  logic [31:0]               i_word_r,
    output logic                      o_done,
    output rmd_pkg::t_cv              o_cv
);
    logic        r_run, r_ex, r_fin;
    logic [5:0]  r_rd_cnt, r_ex_idx;
    rmd_pkg::t_cv r_cv;
    logic [31:0] r_la, r_lb, r_lc, r_ld, r_ra, r_rb, r_rc, r_rd;
    logic [31:0] s_tl, s_tr;
    logic [1:0]  s_rnd;

    assign o_raddr_l = rmd_pkg::WL[r_rd_cnt][rmd_pkg::AddrW-1:0];
    assign o_raddr_r = rmd_pkg::WR[r_rd_cnt][rmd_pkg::AddrW-1:0];
    assign o_done    = r_fin;
    assign o_cv      = r_cv;

    // one step of each line
    always_comb begin
        s_rnd = r_ex_idx[5:4];
        s_tl = rmd_pkg::rotl(r_la + rmd_pkg::mix(s_rnd, r_lb, r_lc, r_ld) + i_word_l
                             + rmd_pkg::KL[s_rnd], rmd_pkg::SL[r_ex_idx]);
        s_tr = rmd_pkg::rotl(r_ra + rmd_pkg::mix(~s_rnd, r_rb, r_rc, r_rd) + i_word_r
                             + rmd_pkg::KR[s_rnd], rmd_pkg::SR[r_ex_idx]);
    end

    // sequence reads, advance the lines, fold into the chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_ex     <= 1'b0;
            r_fin    <= 1'b0;
            r_rd_cnt <= '0;
            r_ex_idx <= '0;
            r_cv     <= rmd_pkg::IV;
        end else begin
            r_ex  <= r_run;
            r_fin <= r_ex && (r_ex_idx == 6'd63);
            if (r_run) begin
                r_ex_idx <= r_rd_cnt;
                r_rd_cnt <= r_rd_cnt + 6'd1;
                if (r_rd_cnt == 6'd63) begin
                    r_run <= 1'b0;
                end
            end
            if (i_start) begin
                r_run    <= 1'b1;
                r_rd_cnt <= '0;
                r_la <= r_cv[0]; r_lb <= r_cv[1]; r_lc <= r_cv[2]; r_ld <= r_cv[3];
                r_ra <= r_cv[0]; r_rb <= r_cv[1]; r_rc <= r_cv[2]; r_rd <= r_cv[3];
            end
            if (r_ex) begin
                r_la <= r_ld; r_ld <= r_lc; r_lc <= r_lb; r_lb <= s_tl;
                r_ra <= r_rd; r_rd <= r_rc; r_rc <= r_rb; r_rb <= s_tr;
            end
            if (r_fin) begin
                r_cv[0] <= r_cv[1] + r_lc + r_rd;
                r_cv[1] <= r_cv[2] + r_ld + r_ra;
                r_cv[2] <= r_cv[3] + r_la + r_rb;
                r_cv[3] <= r_cv[0] + r_lb + r_rc;
            end
            if (i_init) begin
                r_cv <= rmd_pkg::IV;
            end
        end
    end
endmodule

>>> rtl/ripemd128_hash.sv
// RIPEMD-128 hash top level: byte packing, padding sequencer, digest output.
// Depends on rmd_pkg, rmd_ram and rmd_comp.
//
//  channel | direction | valid      | stall       | payload
//  input   | in        | i_in_valid | o_in_stall  | i_in_data  (rmd_pkg::t_in)
//  output  | out       | o_out_valid| i_out_stall | o_out_data (rmd_pkg::t_out)
//
// One byte item is taken per cycle while no block is being compressed, padded or output.
// Each full 64-byte block stalls the input while it is compressed (64 steps in the
// compression engine, one RAM read and one fold).
// End of message adds up to 18 padding word writes and one or two
// compressions, then four digest items; input is stalled until the last one.
// Synchronous active-low reset loads the initial chaining words and zeroes
// the byte count; the block RAM needs no clearing.
module ripemd128_hash (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rmd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rmd_pkg::t_out o_out_data
);
    localparam int AddrW = rmd_pkg::AddrW;
    localparam int CntW  = rmd_pkg::CntW;

    typedef enum logic [2:0] {S_IN, S_CMP, S_PAD, S_ZERO, S_LEN, S_OUT} t_state;

    t_state          r_state, r_after;
    logic [CntW-1:0] r_cnt;
    logic [23:0]     r_acc;
    logic [AddrW-1:0] r_wa;
    logic            r_wrap;
    logic [1:0]      r_oi;

    logic            s_acc_in, s_acc_out, s_we, s_start, s_init, s_done;
    logic [AddrW-1:0] s_waddr, s_pw, s_ra_l, s_ra_r;
    logic [31:0]     s_wdata, s_pad, s_wl, s_wr;
    logic [63:0]     s_bits;
    logic [5:0]      s_pos;
    rmd_pkg::t_cv    s_cv;

    assign o_in_stall  = (r_state != S_IN);
    assign o_out_valid = (r_state == S_OUT);
    assign s_acc_in    = i_in_valid && (r_state == S_IN);
    assign s_acc_out   = o_out_valid && !i_out_stall;
    assign s_pos       = r_cnt[5:0];
    assign s_pw        = s_pos[5:2];
    assign s_bits      = {r_cnt, 3'b000};
    assign s_init      = s_acc_out && (r_oi == 2'd3);

    assign o_out_data.digest_word = s_cv[r_oi];
    assign o_out_data.word_index  = r_oi;
    assign o_out_data.last_word   = (r_oi == 2'd3);

    // build the padding word: kept bytes, then 0x80, then zeros
    always_comb begin
        s_pad = 32'h0;
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < s_pos[1:0]) begin
                s_pad[8*j +: 8] = r_acc[8*j +: 8];
            end
        end
        s_pad[8*s_pos[1:0] +: 8] = 8'h80;
    end

    // drive the RAM write port and the compression start
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_wa;
        s_wdata = 32'h0;
        s_start = 1'b0;
        case (r_state)
            S_IN: begin
                s_waddr = s_pw;
                s_wdata = {i_in_data.data_byte, r_acc};
                s_we    = s_acc_in && i_in_data.byte_valid && (s_pos[1:0] == 2'd3);
                s_start = s_acc_in && i_in_data.byte_valid && (s_pos == 6'd63);
            end
            S_PAD: begin
                s_we    = 1'b1;
                s_waddr = s_pw;
                s_wdata = s_pad;
                s_start = (s_pw == 4'd15);
            end
            S_ZERO: begin
                s_we    = 1'b1;
                s_start = r_wrap;
            end
            S_LEN: begin
                s_we    = 1'b1;
                s_wdata = (r_wa == 4'd14) ? s_bits[31:0] : s_bits[63:32];
                s_start = (r_wa == 4'd15);
            end
            default: ;
        endcase
    end

    // sequence input, padding, compression and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_after <= S_IN;
            r_cnt   <= '0;
            r_wa    <= '0;
            r_wrap  <= 1'b0;
            r_oi    <= '0;
        end else begin
            case (r_state)
                S_IN: begin
                    if (s_acc_in) begin
                        if (i_in_data.byte_valid) begin
                            r_cnt <= r_cnt + CntW'(1);
                            if (s_pos[1:0] != 2'd3) begin
                                r_acc[8*s_pos[1:0] +: 8] <= i_in_data.data_byte;
                            end
                        end
                        if (s_start) begin
                            r_state <= S_CMP;
                            r_after <= i_in_data.end_of_message ? S_PAD : S_IN;
                        end else if (i_in_data.end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_CMP: begin
                    if (s_done) begin
                        r_state <= r_after;
                    end
                end
                S_PAD: begin
                    r_wrap <= 1'b0;
                    if (s_pw == 4'd15) begin
                        r_state <= S_CMP;
                        r_after <= S_ZERO;
                        r_wa    <= '0;
                    end else if (s_pw == 4'd14) begin
                        r_state <= S_ZERO;
                        r_wa    <= 4'd15;
                        r_wrap  <= 1'b1;
                    end else if (s_pw == 4'd13) begin
                        r_state <= S_LEN;
                        r_wa    <= 4'd14;
                    end else begin
                        r_state <= S_ZERO;
                        r_wa    <= s_pw + 4'd1;
                    end
                end
                S_ZERO: begin
                    if (r_wrap) begin
                        r_state <= S_CMP;
                        r_after <= S_ZERO;
                        r_wa    <= '0;
                        r_wrap  <= 1'b0;
                    end else if (r_wa == 4'd13) begin
                        r_state <= S_LEN;
                        r_wa    <= 4'd14;
                    end else begin
                        r_wa <= r_wa + 4'd1;
                    end
                end
                S_LEN: begin
                    if (r_wa == 4'd15) begin
                        r_state <= S_CMP;
                        r_after <= S_OUT;
                        r_oi    <= '0;
                    end else begin
                        r_wa <= 4'd15;
                    end
                end
                S_OUT: begin
                    if (s_acc_out) begin
                        r_oi <= r_oi + 2'd1;
                        if (r_oi == 2'd3) begin
                            r_state <= S_IN;
                            r_cnt   <= '0;
                        end
                    end
                end
                default: r_state <= S_IN;
            endcase
        end
    end

    rmd_ram #(.Width(32), .Depth(2**AddrW)) u_ram_l (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_ra_l), .o_rdata(s_wl)
    );

    rmd_ram #(.Width(32), .Depth(2**AddrW)) u_ram_r (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_ra_r), .o_rdata(s_wr)
    );

    rmd_comp u_comp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(s_start), .i_init(s_init),
        .o_raddr_l(s_ra_l), .o_raddr_r(s_ra_r), .i_word_l(s_wl), .i_word_r(s_wr),
        .o_done(s_done), .o_cv(s_cv)
    );
endmodule

>>> rtl/rmd_checker.sv
// Port-level checks for the RIPEMD-128 hash top level, bound to it below.
// Depends on rmd_pkg for the channel payload types.
module rmd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input rmd_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input rmd_pkg::t_out o_out_data
);
    // hold a stalled digest item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled digest item changed");

    // take no byte while digest words are pending
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open during digest output");

    // flag the fourth word as last
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last_word == (o_out_data.word_index == 2'd3)))
        else $error("last_word does not match word_index");

    // drop output after the last word goes
    a_end_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_data.last_word |=> !o_out_valid)
        else $error("output continued past last word");

    // advance the index by one on each taken word
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.last_word
        |=> o_out_valid && (o_out_data.word_index == $past(o_out_data.word_index) + 2'd1))
        else $error("digest word index skipped");
endmodule

bind ripemd128_hash rmd_checker u_rmd_checker (.*);

>>> test/ripemd128_hash_tb.sv
// Testbench for ripemd128_hash: random and directed byte streams, digests checked
// against a behavioral RIPEMD-128 digest calculator. Depends on rmd_pkg and the RTL.
module ripemd128_hash_tb;

    localparam int LIMIT_CYCLES = 2000000;

    // Digest calculator and queue of pending digest words
    class digest_board;
        logic [31:0]   cv [4];
        logic [7:0]    blk [64];
        logic [60:0]   nbytes;
        rmd_pkg::t_out pending [$];
        int            errors;
        int            words_seen;
        int            messages;

        function new();
            errors = 0;
            words_seen = 0;
            messages = 0;
            restart();
        endfunction

        function void restart();
            cv[0] = 32'h67452301;
            cv[1] = 32'hEFCDAB89;
            cv[2] = 32'h98BADCFE;
            cv[3] = 32'h10325476;
            foreach (blk[i]) blk[i] = 8'h00;
            nbytes = '0;
        endfunction

        function logic [31:0] rol(logic [31:0] v, int s);
            return (s == 0) ? v : ((v << s) | (v >> (32 - s)));
        endfunction

        function logic [31:0] fsel(int sel, logic [31:0] x, logic [31:0] y, logic [31:0] z);
            case (sel)
                0: return x ^ y ^ z;
                1: return (x & y) | (~x & z);
                2: return (x | ~y) ^ z;
                default: return (x & z) | (y & ~z);
            endcase
        endfunction

        function void crunch();
            logic [31:0] w [16];
            logic [31:0] la, lb, lc, ld, ra, rb, rc, rd, t;
            int          r;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
            la = cv[0]; lb = cv[1]; lc = cv[2]; ld = cv[3];
            ra = cv[0]; rb = cv[1]; rc = cv[2]; rd = cv[3];
            for (int i = 0; i < 64; i++) begin
                r = i / 16;
                t = rol(la + fsel(r, lb, lc, ld) + w[rmd_pkg::WL[i]] + rmd_pkg::KL[r],
                        rmd_pkg::SL[i]);
                la = ld; ld = lc; lc = lb; lb = t;
                t = rol(ra + fsel(3 - r, rb, rc, rd) + w[rmd_pkg::WR[i]] + rmd_pkg::KR[r],
                        rmd_pkg::SR[i]);
                ra = rd; rd = rc; rc = rb; rb = t;
            end
            t = cv[1] + lc + rd;
            cv[1] = cv[2] + ld + ra;
            cv[2] = cv[3] + la + rb;
            cv[3] = cv[0] + lb + rc;
            cv[0] = t;
        endfunction

        // Note an accepted input item and queue any digest words it causes
        function void note_item(rmd_pkg::t_in it);
            logic [63:0]   bitlen;
            int            pos;
            rmd_pkg::t_out o;
            if (it.byte_valid) begin
                blk[nbytes[5:0]] = it.data_byte;
                nbytes = nbytes + 61'd1;
                if (nbytes[5:0] == 6'd0) crunch();
            end
            if (!it.end_of_message) return;
            bitlen = {nbytes, 3'b000};
            pos = int'(nbytes[5:0]);
            blk[pos] = 8'h80;
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin blk[pos] = 8'h00; pos++; end
                crunch();
                pos = 0;
            end
            while (pos < 56) begin blk[pos] = 8'h00; pos++; end
            for (int k = 0; k < 8; k++) blk[56+k] = bitlen[8*k +: 8];
            crunch();
            for (int k = 0; k < 4; k++) begin
                o.digest_word = cv[k];
                o.word_index = k[1:0];
                o.last_word = (k == 3);
                pending.push_back(o);
            end
            messages++;
            restart();
        endfunction

        // Compare an accepted digest word with the oldest expectation
        function void check_word(rmd_pkg::t_out got);
            rmd_pkg::t_out exp_w;
            words_seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected digest word %h", $time, got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.digest_word !== exp_w.digest_word) begin
                $display("%0t: digest_word expected %h actual %h", $time,
                         exp_w.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== exp_w.word_index) begin
                $display("%0t: word_index expected %0d actual %0d", $time,
                         exp_w.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== exp_w.last_word) begin
                $display("%0t: last_word expected %0d actual %0d", $time,
                         exp_w.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    rmd_pkg::t_in  i_in_data = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    rmd_pkg::t_out o_out_data;

    digest_board board;
    int          cycles = 0;
    int          items_sent = 0;
    bit          rx_on = 1'b0;

    ripemd128_hash i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Check outputs and drive the random receiver stall
    always @(posedge i_clk) begin
        if (rx_on && o_out_valid && !i_out_stall) board.check_word(o_out_data);
        if (rx_on) i_out_stall <= (gap_len() != 0);
    end

    // Send one item, waiting for it to be taken; valid stays up for a back-to-back item
    task automatic send_item(logic [7:0] b, logic bv, logic eom, bit idle_gaps);
        rmd_pkg::t_in it;
        int           g;
        it.data_byte = b;
        it.byte_valid = bv;
        it.end_of_message = eom;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_item(it);
        items_sent++;
        g = idle_gaps ? gap_len() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            i_in_data <= '0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Send a message of given length with random bytes and optional noise
    task automatic send_message(int len, bit idle_gaps, bit noise);
        for (int i = 0; i < len; i++) begin
            if (noise && $urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, idle_gaps);
            if (i == len - 1 && $urandom_range(0, 1))
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1, idle_gaps);
            else begin
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, idle_gaps);
                if (i == len - 1)
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, idle_gaps);
            end
        end
        if (len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, idle_gaps);
    endtask

    // Drop valid and wait for every pending digest word
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rx_on = 1'b1;

        // Directed: empty message, extreme bytes, idle items, padding edges
        send_item(8'h00, 1'b0, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1, 1'b0);
        send_item(8'hA5, 1'b1, 1'b1, 1'b0);
        send_item(8'h5A, 1'b1, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1, 1'b0);
        drain();
        send_message(55, 1'b0, 1'b0);
        send_message(56, 1'b1, 1'b0);
        send_message(64, 1'b0, 1'b0);

        // Hold off until every pending digest has come out
        drain();

        // Random messages, mostly short, a few spanning several blocks
        while (items_sent < 360) begin
            if ($urandom_range(0, 9) == 0)
                send_message($urandom_range(60, 130), 1'b1, 1'b1);
            else
                send_message($urandom_range(0, 12), 1'b1, 1'b1);
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("Sent %0d items forming %0d messages; checked %0d digest words.",
                 items_sent, board.messages, board.words_seen);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/rmd_pkg.sv
rtl/rmd_ram.sv
rtl/rmd_comp.sv
rtl/ripemd128_hash.sv
rtl/rmd_checker.sv
test/ripemd128_hash_tb.sv
